// ===== rtl/core/hrd_pkg.sv =====
// Package for the H.264 RTP depacketizer: result word type, NAL type codes, queue sizing.
`timescale 1ns / 1ps
package hrd_pkg;

    // NAL unit type codes of interest
    localparam logic [4:0]  NAL_TYPE_STAPA = 5'd24;
    localparam logic [4:0]  NAL_TYPE_FUA   = 5'd28;
    // STAP-A length prefix size in bytes
    localparam logic [15:0] STAP_LEN_BYTES = 16'd2;

    // queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // one result word
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       nal_first;
        logic       nal_last;
        logic       nal_abort;
        logic       packet_done;
        logic       packet_ok;
    } t_result;

    // queue status seen by parser and output stage
    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] count;
    } t_queue_status;

endpackage

// ===== rtl/core/hrd_if.sv =====
// Handshake channel interfaces: payload byte input and NAL byte output.
`timescale 1ns / 1ps
interface hrd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic [15:0] payload_length;

    modport source (output valid, output payload_byte, output first_byte,
                    output payload_length, input ready);
    modport sink   (input valid, input payload_byte, input first_byte,
                    input payload_length, output ready);
endinterface

interface hrd_out_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       nal_first;
    logic       nal_last;
    logic       nal_abort;
    logic       packet_done;
    logic       packet_ok;

    modport source (output valid, output byte_valid, output out_byte, output nal_first,
                    output nal_last, output nal_abort, output packet_done,
                    output packet_ok, input ready);
    modport sink   (input valid, input byte_valid, input out_byte, input nal_first,
                    input nal_last, input nal_abort, input packet_done,
                    input packet_ok, output ready);
endinterface

// ===== rtl/core/hrd_front.sv =====
// Front end: accepts payload bytes, parses single NAL / STAP-A / FU-A, builds result words.
`timescale 1ns / 1ps
module hrd_front
    import hrd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    hrd_in_if.sink        i_in,
    input  t_queue_status i_qstat,
    output logic          o_push,
    output t_result       o_result
);

    // parse phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_SINGLE     = 4'd1;
    localparam logic [3:0] PH_FUA_HDR    = 4'd2;
    localparam logic [3:0] PH_FUA_DATA   = 4'd3;
    localparam logic [3:0] PH_STAP_HI    = 4'd4;
    localparam logic [3:0] PH_STAP_LO    = 4'd5;
    localparam logic [3:0] PH_STAP_FIRST = 4'd6;
    localparam logic [3:0] PH_STAP_DATA  = 4'd7;
    localparam logic [3:0] PH_DRAIN      = 4'd8;

    logic [3:0]  r_phase,     n_phase;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_sub_left,  n_sub_left;
    logic [7:0]  r_len_hi,    n_len_hi;
    logic [1:0]  r_nri,       n_nri;
    logic        r_frag_open, n_frag_open;
    logic        r_frag_ends, n_frag_ends;
    logic        r_failed,    n_failed;

    logic        accept;
    logic        fail;
    logic [7:0]  b;
    logic [4:0]  nal_type;
    logic [15:0] rem;
    logic [15:0] stap_size;
    logic [15:0] sub_dec;
    t_result     res;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && !i_qstat.full;
    assign b          = i_in.payload_byte;
    assign nal_type   = b[4:0];
    assign rem        = r_bytes_left - 16'd1;
    assign stap_size  = {r_len_hi, b};
    assign sub_dec    = r_sub_left - 16'd1;

    // parser next state and result word
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_sub_left   = r_sub_left;
        n_len_hi     = r_len_hi;
        n_nri        = r_nri;
        n_frag_open  = r_frag_open;
        n_frag_ends  = r_frag_ends;
        n_failed     = r_failed;
        res          = '0;
        fail         = 1'b0;
        o_push       = 1'b0;

        if (accept) begin
            if (i_in.first_byte) begin
                o_push = 1'b1;
                // truncation of an unfinished payload
                if (r_phase != PH_IDLE) begin
                    if (r_frag_open || r_phase == PH_SINGLE || r_phase == PH_STAP_DATA)
                        res.nal_abort = 1'b1;
                    n_frag_open = 1'b0;
                end
                n_phase      = PH_IDLE;
                n_failed     = 1'b0;
                n_bytes_left = '0;
                if (i_in.payload_length == 16'd0) begin
                    res.packet_done = 1'b1;
                end else begin
                    n_bytes_left = i_in.payload_length - 16'd1;
                    if (b[7]) begin
                        fail = 1'b1;
                    end else if (nal_type == NAL_TYPE_FUA) begin
                        if (i_in.payload_length <= 16'd2) begin
                            if (n_frag_open) res.nal_abort = 1'b1;
                            n_frag_open = 1'b0;
                            fail        = 1'b1;
                        end else begin
                            n_nri   = b[6:5];
                            n_phase = PH_FUA_HDR;
                        end
                    end else begin
                        if (n_frag_open) res.nal_abort = 1'b1;
                        n_frag_open = 1'b0;
                        if (nal_type == NAL_TYPE_STAPA) begin
                            if (i_in.payload_length == 16'd1) begin
                                res.packet_done = 1'b1;
                                res.packet_ok   = 1'b1;
                            end else begin
                                n_phase = PH_STAP_HI;
                            end
                        end else if (nal_type < NAL_TYPE_STAPA) begin
                            res.byte_valid = 1'b1;
                            res.out_byte   = b;
                            res.nal_first  = 1'b1;
                            if (i_in.payload_length == 16'd1) begin
                                res.nal_last    = 1'b1;
                                res.packet_done = 1'b1;
                                res.packet_ok   = 1'b1;
                            end else begin
                                n_phase = PH_SINGLE;
                            end
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    if (fail) begin
                        n_failed = 1'b1;
                        if (i_in.payload_length == 16'd1) res.packet_done = 1'b1;
                        else                               n_phase = PH_DRAIN;
                    end
                end
            end else if (r_phase != PH_IDLE) begin
                // continuation byte inside a payload
                o_push       = 1'b1;
                n_bytes_left = rem;
                case (r_phase)
                    PH_SINGLE: begin
                        res.byte_valid = 1'b1;
                        res.out_byte   = b;
                        res.nal_last   = (rem == 16'd0);
                    end
                    PH_FUA_HDR: begin
                        if ((b[7] && b[6]) || (!b[7] && !r_frag_open)
                            || nal_type >= NAL_TYPE_STAPA) begin
                            if (r_frag_open) res.nal_abort = 1'b1;
                            n_frag_open = 1'b0;
                            fail        = 1'b1;
                        end else begin
                            if (b[7]) begin
                                res.nal_abort  = r_frag_open;
                                n_frag_open    = 1'b1;
                                res.byte_valid = 1'b1;
                                res.nal_first  = 1'b1;
                                res.out_byte   = {1'b0, r_nri, nal_type};
                            end
                            n_frag_ends = b[6];
                            n_phase     = PH_FUA_DATA;
                        end
                    end
                    PH_FUA_DATA: begin
                        res.byte_valid = 1'b1;
                        res.out_byte   = b;
                        if (rem == 16'd0 && r_frag_ends) begin
                            res.nal_last = 1'b1;
                            n_frag_open  = 1'b0;
                        end
                    end
                    PH_STAP_HI: begin
                        if (rem < STAP_LEN_BYTES) begin
                            fail = 1'b1;
                        end else begin
                            n_len_hi = b;
                            n_phase  = PH_STAP_LO;
                        end
                    end
                    PH_STAP_LO: begin
                        if (stap_size == 16'd0 || stap_size > rem) begin
                            fail = 1'b1;
                        end else begin
                            n_sub_left = stap_size;
                            n_phase    = PH_STAP_FIRST;
                        end
                    end
                    PH_STAP_FIRST, PH_STAP_DATA: begin
                        res.byte_valid = 1'b1;
                        res.out_byte   = b;
                        res.nal_first  = (r_phase == PH_STAP_FIRST);
                        n_sub_left     = sub_dec;
                        if (sub_dec == 16'd0) begin
                            res.nal_last = 1'b1;
                            n_phase      = PH_STAP_HI;
                        end else begin
                            n_phase = PH_STAP_DATA;
                        end
                    end
                    default: begin
                    end
                endcase
                if (fail) begin
                    n_failed = 1'b1;
                    n_phase  = PH_DRAIN;
                end
                // last byte of the payload
                if (rem == 16'd0) begin
                    res.packet_done = 1'b1;
                    res.packet_ok   = !n_failed;
                    n_phase         = PH_IDLE;
                end
            end
        end
    end

    assign o_result = res;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_sub_left   <= '0;
            r_len_hi     <= '0;
            r_nri        <= '0;
            r_frag_open  <= 1'b0;
            r_frag_ends  <= 1'b0;
            r_failed     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_sub_left   <= n_sub_left;
            r_len_hi     <= n_len_hi;
            r_nri        <= n_nri;
            r_frag_open  <= n_frag_open;
            r_frag_ends  <= n_frag_ends;
            r_failed     <= n_failed;
        end
    end

endmodule

// ===== rtl/core/hrd_queue.sv =====
// Short result queue between parser and output stage.
`timescale 1ns / 1ps
module hrd_queue
    import hrd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_data,
    input  logic          i_pop,
    output t_result       o_data,
    output t_queue_status o_stat
);

    localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CW-1:0] FULL_CNT = QUEUE_CW'(QUEUE_DEPTH);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count,  n_count;
    logic                do_push;
    logic                do_pop;

    assign do_push = i_push && (r_count != FULL_CNT);
    assign do_pop  = i_pop && (r_count != '0);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage words
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

// ===== rtl/core/hrd_back.sv =====
// Back end: output register that drains the result queue onto the output channel.
`timescale 1ns / 1ps
module hrd_back
    import hrd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_qstat,
    input  t_result       i_data,
    output logic          o_pop,
    hrd_out_if.source     o_out
);

    logic    r_valid, n_valid;
    t_result r_word;
    logic    load;

    // refill whenever the register is empty or being taken
    assign load  = !r_valid || o_out.ready;
    assign o_pop = load && !i_qstat.empty;

    always_comb begin
        n_valid = r_valid;
        if (load) n_valid = !i_qstat.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_word <= i_data;
    end

    assign o_out.valid       = r_valid;
    assign o_out.byte_valid  = r_word.byte_valid;
    assign o_out.out_byte    = r_word.out_byte;
    assign o_out.nal_first   = r_word.nal_first;
    assign o_out.nal_last    = r_word.nal_last;
    assign o_out.nal_abort   = r_word.nal_abort;
    assign o_out.packet_done = r_word.packet_done;
    assign o_out.packet_ok   = r_word.packet_ok;

endmodule

// ===== rtl/core/h264_rtp_depacketizer.sv =====
// Top level of the H.264 RTP depacketizer (single NAL, STAP-A, FU-A).
//
// Input channel i_in: one RTP payload byte per word; first_byte marks the
// start of a payload and payload_length is sampled with it. Output channel
// o_out: one result word per payload byte (one for an empty payload) giving
// the NAL byte with first/last marks, abort of an open fragment, and the
// packet done/ok status. Stray bytes outside a payload give no word.
// The parser takes one byte per cycle while the queue is not full and pushes
// its result into a four-word queue; an output register drains the queue. A
// word passes through the queue and then the output register before it
// appears on o_out. Sustained rate is one byte per cycle while the receiver
// keeps ready high.
// Reset (i_rst_n low, synchronous) returns the parser to idle with no open
// fragment and empties the queue and output register.
// When the receiver stalls, the output word holds and the queue fills;
// i_in.ready falls once the queue is full and rises as words are taken.
`timescale 1ns / 1ps
module h264_rtp_depacketizer
    import hrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrd_in_if.sink    i_in,
    hrd_out_if.source o_out
);

    logic          push;
    logic          pop;
    t_result       front_word;
    t_result       queue_word;
    t_queue_status qstat;

    hrd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_result (front_word)
    );

    hrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_word),
        .i_pop   (pop),
        .o_data  (queue_word),
        .o_stat  (qstat)
    );

    hrd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_data  (queue_word),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // parser never produces a word into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("result pushed into full queue");

    // fill count follows pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        (qstat.count == $past(qstat.count) + QUEUE_CW'($past(push))
                        - QUEUE_CW'($past(pop) && !$past(qstat.empty))))
        else $error("queue fill count out of step");

    // nothing presented on the output right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

endmodule

// ===== test/h264_rtp_depacketizer_tb.sv =====
// Testbench for the H.264 RTP depacketizer: random payload traffic against a parser model.
`timescale 1ns / 1ps
module h264_rtp_depacketizer_tb;
    import hrd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 560;

    // parser phases of the model
    typedef enum logic [3:0] {
        PH_IDLE, PH_SINGLE, PH_FUA_HDR, PH_FUA_DATA,
        PH_STAP_HI, PH_STAP_LO, PH_STAP_FIRST, PH_STAP_DATA, PH_DRAIN
    } t_phase;

    // one input word as offered to the block
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first_byte;
        logic [15:0] payload_length;
    } t_in_word;

    logic i_clk;
    logic i_rst_n;

    hrd_in_if  in_if ();
    hrd_out_if out_if ();

    h264_rtp_depacketizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_in_word   pending_bytes[$];
    t_result    expected_words[$];
    logic [7:0] pl_buf[$];

    // model state
    t_phase      prs_phase;
    logic [15:0] prs_left;
    logic [15:0] prs_unit_left;
    logic [7:0]  prs_len_hi;
    logic [1:0]  prs_nri;
    logic        prs_frag_open;
    logic        prs_frag_ends;
    logic        prs_failed;

    // driver and receiver bookkeeping
    t_in_word drv_word;
    t_result  drv_result;
    int       burst_left;
    int       gap_left;
    int       rx_cycle;
    int       rx_mode;
    int       rx_mode_left;
    int       hold_left;
    int       hold_offs;
    int       idle_cycles;

    // tallies
    int bytes_taken;
    int words_seen;
    int nal_units;
    int nal_aborts;
    int packets_ok;
    int packets_bad;
    int failures;

    // Expected result word for one accepted input word; returns 0 when the
    // word is a stray byte outside any payload.
    function automatic bit depacketize_byte(input t_in_word w, output t_result r);
        logic [4:0]  nal_type;
        logic [4:0]  frag_type;
        logic [15:0] rem;
        logic [15:0] unit_size;
        logic        fu_start;
        logic        fu_end;
        bit          fail;
        r = '0;
        fail = 1'b0;
        if (w.first_byte) begin
            // truncation of an unfinished payload
            if (prs_phase != PH_IDLE) begin
                if (prs_frag_open || prs_phase == PH_SINGLE || prs_phase == PH_STAP_DATA)
                    r.nal_abort = 1'b1;
                prs_frag_open = 1'b0;
            end
            prs_phase = PH_IDLE;
            prs_failed = 1'b0;
            prs_left = '0;
            if (w.payload_length == 16'd0) begin
                r.packet_done = 1'b1;
            end else begin
                nal_type = w.payload_byte[4:0];
                prs_left = w.payload_length - 16'd1;
                if (w.payload_byte[7]) begin
                    fail = 1'b1;
                end else if (nal_type == NAL_TYPE_FUA) begin
                    if (w.payload_length <= 16'd2) begin
                        if (prs_frag_open) r.nal_abort = 1'b1;
                        prs_frag_open = 1'b0;
                        fail = 1'b1;
                    end else begin
                        prs_nri = w.payload_byte[6:5];
                        prs_phase = PH_FUA_HDR;
                    end
                end else begin
                    // anything but FU-A closes an open fragment
                    if (prs_frag_open) r.nal_abort = 1'b1;
                    prs_frag_open = 1'b0;
                    if (nal_type == NAL_TYPE_STAPA) begin
                        if (prs_left == 16'd0) begin
                            r.packet_done = 1'b1;
                            r.packet_ok = 1'b1;
                        end else begin
                            prs_phase = PH_STAP_HI;
                        end
                    end else if (nal_type < NAL_TYPE_STAPA) begin
                        r.byte_valid = 1'b1;
                        r.out_byte = w.payload_byte;
                        r.nal_first = 1'b1;
                        if (prs_left == 16'd0) begin
                            r.nal_last = 1'b1;
                            r.packet_done = 1'b1;
                            r.packet_ok = 1'b1;
                        end else begin
                            prs_phase = PH_SINGLE;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                if (fail) begin
                    prs_failed = 1'b1;
                    if (prs_left == 16'd0) r.packet_done = 1'b1;
                    else prs_phase = PH_DRAIN;
                end
            end
            return 1'b1;
        end

        if (prs_phase == PH_IDLE) return 1'b0;
        prs_left = prs_left - 16'd1;
        rem = prs_left;
        case (prs_phase)
            PH_SINGLE: begin
                r.byte_valid = 1'b1;
                r.out_byte = w.payload_byte;
                if (rem == 16'd0) r.nal_last = 1'b1;
            end
            PH_FUA_HDR: begin
                fu_start = w.payload_byte[7];
                fu_end = w.payload_byte[6];
                frag_type = w.payload_byte[4:0];
                if ((fu_start && fu_end) || (!fu_start && !prs_frag_open)
                        || frag_type >= NAL_TYPE_STAPA) begin
                    if (prs_frag_open) r.nal_abort = 1'b1;
                    prs_frag_open = 1'b0;
                    fail = 1'b1;
                end else begin
                    if (fu_start) begin
                        // restart drops the old fragment on the header word
                        if (prs_frag_open) r.nal_abort = 1'b1;
                        prs_frag_open = 1'b1;
                        r.byte_valid = 1'b1;
                        r.nal_first = 1'b1;
                        r.out_byte = {1'b0, prs_nri, frag_type};
                    end
                    prs_frag_ends = fu_end;
                    prs_phase = PH_FUA_DATA;
                end
            end
            PH_FUA_DATA: begin
                r.byte_valid = 1'b1;
                r.out_byte = w.payload_byte;
                if (rem == 16'd0 && prs_frag_ends) begin
                    r.nal_last = 1'b1;
                    prs_frag_open = 1'b0;
                end
            end
            PH_STAP_HI: begin
                if (rem < STAP_LEN_BYTES) begin
                    fail = 1'b1;
                end else begin
                    prs_len_hi = w.payload_byte;
                    prs_phase = PH_STAP_LO;
                end
            end
            PH_STAP_LO: begin
                unit_size = {prs_len_hi, w.payload_byte};
                if (unit_size == 16'd0 || unit_size > rem) begin
                    fail = 1'b1;
                end else begin
                    prs_unit_left = unit_size;
                    prs_phase = PH_STAP_FIRST;
                end
            end
            PH_STAP_FIRST, PH_STAP_DATA: begin
                r.byte_valid = 1'b1;
                r.out_byte = w.payload_byte;
                r.nal_first = (prs_phase == PH_STAP_FIRST);
                prs_unit_left = prs_unit_left - 16'd1;
                if (prs_unit_left == 16'd0) begin
                    r.nal_last = 1'b1;
                    prs_phase = PH_STAP_HI;
                end else begin
                    prs_phase = PH_STAP_DATA;
                end
            end
            default: ;
        endcase
        if (fail) begin
            prs_failed = 1'b1;
            prs_phase = PH_DRAIN;
        end
        if (rem == 16'd0) begin
            r.packet_done = 1'b1;
            r.packet_ok = !prs_failed;
            prs_phase = PH_IDLE;
        end
        return 1'b1;
    endfunction

    // queue the bytes in pl_buf as one payload with the given length field
    task automatic send_payload(input logic [15:0] declared);
        t_in_word w;
        foreach (pl_buf[i]) begin
            w.payload_byte = pl_buf[i];
            w.first_byte = (i == 0);
            w.payload_length = (i == 0) ? declared : 16'($urandom_range(0, 65535));
            pending_bytes.push_back(w);
        end
        pl_buf.delete();
    endtask

    task automatic send_stray();
        t_in_word w;
        w.payload_byte = 8'($urandom);
        w.first_byte = 1'b0;
        w.payload_length = 16'($urandom_range(0, 65535));
        pending_bytes.push_back(w);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.payload_byte <= '0;
            in_if.first_byte <= 1'b0;
            in_if.payload_length <= '0;
            prs_phase = PH_IDLE;
            prs_left = '0;
            prs_unit_left = '0;
            prs_len_hi = '0;
            prs_nri = '0;
            prs_frag_open = 1'b0;
            prs_frag_ends = 1'b0;
            prs_failed = 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                bytes_taken++;
                if (depacketize_byte(drv_word, drv_result))
                    expected_words.push_back(drv_result);
            end
            if (!in_if.valid || in_if.ready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left != 0 || pending_bytes.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    in_if.valid <= 1'b0;
                end else begin
                    drv_word = pending_bytes.pop_front();
                    burst_left--;
                    in_if.valid <= 1'b1;
                    in_if.payload_byte <= drv_word.payload_byte;
                    in_if.first_byte <= drv_word.first_byte;
                    in_if.payload_length <= drv_word.payload_length;
                end
            end
        end
    end

    // receiver: changing ready patterns, plus long hold-offs to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_cycle = 0;
            rx_mode = 0;
            rx_mode_left = 0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (rx_cycle == 150 || rx_cycle == 700) begin
                hold_left = $urandom_range(60, 100);
                hold_offs++;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(8, 60);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= 1'($urandom_range(0, 1));
                    default: out_if.ready <= (rx_cycle % 5) < 3;
                endcase
            end
        end
    end

    // checker: each word taken against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.byte_valid, out_if.out_byte, out_if.nal_first, out_if.nal_last,
                    out_if.nal_abort, out_if.packet_done, out_if.packet_ok};
            words_seen++;
            if (got.byte_valid && got.nal_last) nal_units++;
            if (got.nal_abort) nal_aborts++;
            if (got.packet_done && got.packet_ok) packets_ok++;
            if (got.packet_done && !got.packet_ok) packets_bad++;
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("word %0d arrived with nothing expected: %p", words_seen, got);
            end else begin
                want = expected_words.pop_front();
                if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte
                        || got.nal_first !== want.nal_first || got.nal_last !== want.nal_last
                        || got.nal_abort !== want.nal_abort
                        || got.packet_done !== want.packet_done
                        || got.packet_ok !== want.packet_ok) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("word %0d wrong:", words_seen);
                        $display("  expected v=%b byte=%h first=%b last=%b abort=%b done=%b ok=%b",
                                 want.byte_valid, want.out_byte, want.nal_first, want.nal_last,
                                 want.nal_abort, want.packet_done, want.packet_ok);
                        $display("  got      v=%b byte=%h first=%b last=%b abort=%b done=%b ok=%b",
                                 got.byte_valid, got.out_byte, got.nal_first, got.nal_last,
                                 got.nal_abort, got.packet_done, got.packet_ok);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d words still expected",
                     idle_cycles, expected_words.size());
            $display("h264_rtp_depacketizer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int          nfrag;
        int          sz;
        int          n_units;
        logic [1:0]  nri;
        logic [4:0]  ft;
        logic [7:0]  hdr;
        logic [15:0] bad_len;
        logic        skip;

        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.payload_byte = '0;
        in_if.first_byte = 1'b0;
        in_if.payload_length = '0;
        out_if.ready = 1'b0;
        idle_cycles = 0;
        bytes_taken = 0;
        words_seen = 0;
        nal_units = 0;
        nal_aborts = 0;
        packets_ok = 0;
        packets_bad = 0;
        failures = 0;
        hold_offs = 0;

        // empty payload
        pl_buf = '{8'h65};
        send_payload(16'd0);
        // forbidden bit on the all-ones header
        pl_buf = '{8'hFF};
        send_payload(16'd1);
        // plain two-byte NAL unit of type zero
        pl_buf = '{8'h00, 8'hFF};
        send_payload(16'd2);
        // FU-A start, then a second start cut short by the next payload
        pl_buf = '{8'h7C, 8'h85, 8'hAB};
        send_payload(16'd3);
        pl_buf = '{8'h5C, 8'h81, 8'hCD};
        send_payload(16'hFFFF);
        // STAP-A with one unit and a single leftover byte
        pl_buf = '{8'h18, 8'h00, 8'h01, 8'h09, 8'h00};
        send_payload(16'd5);
        // FU-A with start and end both set, then an FU-A too short to parse
        pl_buf = '{8'h7C, 8'hC5, 8'h00};
        send_payload(16'd3);
        pl_buf = '{8'h7C, 8'h85};
        send_payload(16'd2);
        // reserved type
        pl_buf = '{8'h1D};
        send_payload(16'd1);
        // STAP-A unit of zero length
        pl_buf = '{8'h18, 8'h00, 8'h00, 8'h00};
        send_payload(16'd4);
        send_stray();

        while (pending_bytes.size() < ITEM_TARGET) begin
            nri = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 19))
                // fragmented NAL unit, sometimes damaged
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    ft = 5'($urandom_range(0, 23));
                    nfrag = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4);
                    for (int f = 0; f < nfrag; f++) begin
                        hdr = {f == 0, f == nfrag - 1, 1'($urandom_range(0, 1)), ft};
                        skip = 1'b0;
                        case ($urandom_range(0, 19))
                            0: hdr[4:0] = 5'($urandom_range(24, 31));
                            1: hdr[7:6] = 2'b11;
                            2: skip = 1'b1;
                            default: ;
                        endcase
                        if (!skip) begin
                            pl_buf = '{{1'b0, nri, NAL_TYPE_FUA}, hdr};
                            repeat ($urandom_range(1, 6)) pl_buf.push_back(8'($urandom));
                            send_payload(16'(pl_buf.size()));
                        end
                    end
                end
                // aggregation packet, sometimes damaged
                8, 9, 10, 11: begin
                    pl_buf = '{{1'b0, nri, NAL_TYPE_STAPA}};
                    n_units = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                    repeat (n_units) begin
                        sz = $urandom_range(1, 6);
                        case ($urandom_range(0, 11))
                            0: bad_len = 16'd0;
                            1: bad_len = 16'($urandom_range(sz + 1, 65535));
                            default: bad_len = 16'(sz);
                        endcase
                        pl_buf.push_back(bad_len[15:8]);
                        pl_buf.push_back(bad_len[7:0]);
                        repeat (sz) pl_buf.push_back(8'($urandom));
                    end
                    if ($urandom_range(0, 7) == 0)
                        repeat ($urandom_range(1, 2)) pl_buf.push_back(8'($urandom));
                    send_payload(16'(pl_buf.size()));
                end
                // single NAL unit, now and then a long one
                12, 13, 14: begin
                    pl_buf = '{{1'b0, nri, 5'($urandom_range(0, 23))}};
                    repeat (($urandom_range(0, 19) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(0, 7))
                        pl_buf.push_back(8'($urandom));
                    send_payload(16'(pl_buf.size()));
                end
                // noise and broken payloads
                default: begin
                    case ($urandom_range(0, 5))
                        0: begin
                            pl_buf = '{8'($urandom)};
                            send_payload(16'd0);
                        end
                        1: begin
                            pl_buf = '{8'($urandom)};
                            repeat ($urandom_range(0, 4)) pl_buf.push_back(8'($urandom));
                            send_payload(16'(pl_buf.size()));
                        end
                        2: begin
                            // declared longer than sent: cut off by the next payload
                            pl_buf = '{8'($urandom)};
                            repeat ($urandom_range(0, 4)) pl_buf.push_back(8'($urandom));
                            send_payload(($urandom_range(0, 3) == 0) ? 16'hFFFF
                                : 16'($urandom_range(pl_buf.size() + 1, 65535)));
                        end
                        3: repeat ($urandom_range(1, 3)) send_stray();
                        4: begin
                            pl_buf = '{{1'b0, nri, NAL_TYPE_FUA}};
                            if ($urandom_range(0, 1) == 1) pl_buf.push_back(8'($urandom));
                            send_payload(16'(pl_buf.size()));
                        end
                        default: begin
                            // declared one short: the last byte falls outside the payload
                            pl_buf = '{{1'b0, nri, 5'($urandom_range(0, 23))}};
                            repeat ($urandom_range(1, 4)) pl_buf.push_back(8'($urandom));
                            send_payload(16'(pl_buf.size() - 1));
                        end
                    endcase
                end
            endcase
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_if.valid || expected_words.size() != 0);
        repeat (20) @(posedge i_clk);

        $display("run: %0d payload bytes in, %0d result words, %0d NAL units closed, %0d aborted",
                 bytes_taken, words_seen, nal_units, nal_aborts);
        $display("run: %0d payloads clean, %0d rejected, %0d long receiver hold-offs, %0d errors",
                 packets_ok, packets_bad, hold_offs, failures);
        if (failures == 0) begin
            $display("h264_rtp_depacketizer: match");
        end else begin
            $display("h264_rtp_depacketizer: mismatch");
        end
        $finish;
    end

endmodule
